### rtl/core/opf_pkg.sv
// ----------------------------------------------------------------------------
// opf_pkg
// Shared types and register codes for the one-pole filter with peak track.
// ----------------------------------------------------------------------------
package opf_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK = 2'd2;

    typedef struct packed {
        logic reload;
        logic peak_en;
    } t_ctl;

endpackage

### rtl/core/one_pole_filter_with_peak_track_core.sv
// ----------------------------------------------------------------------------
// one_pole_filter_with_peak_track_core
// One-pole low-pass filter with optional running max/min tracking.
//
//   channel  dir  handshake                 payload
//   in       in   i_in_valid / o_in_stall   i_sample
//   out      out  o_out_valid / i_out_stall o_filtered, o_peak_max, o_peak_min
//   cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; a taken item passes the input register, then opf_update's state.
// The feedback multiply c * y and the add are combinational in opf_update, ahead of its state register.
// Reset clears the state and all registers but the input term register to zero; no clearing pass.
// A config write is taken every cycle; a write to a defined index reloads the state in the cycle after.
// A stalled result holds unless a config reload comes; the input register stalls only when both stages are full.
// ----------------------------------------------------------------------------
module one_pole_filter_with_peak_track_core
    import opf_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] o_filtered,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] o_peak_max,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] o_peak_min,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                    i_cfg_index,
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0]        i_cfg_data
);

    localparam int VAL_W = SAMPLE_BITS + FRAC_BITS;

    logic [FRAC_BITS:0]      coef;
    logic signed [VAL_W-1:0] init;
    t_ctl                    ctl;
    logic                    advance;
    logic                    a_valid;
    logic signed [VAL_W:0]   a_term;

    assign o_cfg_ready = 1'b1;

    opf_cfg #(
        .FRAC_BITS (FRAC_BITS),
        .VAL_W     (VAL_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef),
        .o_init      (init),
        .o_ctl       (ctl)
    );

    opf_input_stage #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_input (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_sample  (i_sample),
        .o_stall   (o_in_stall),
        .i_coef    (coef),
        .i_advance (advance),
        .o_valid   (a_valid),
        .o_term    (a_term)
    );

    opf_update #(
        .FRAC_BITS (FRAC_BITS),
        .VAL_W     (VAL_W)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (a_valid),
        .i_term      (a_term),
        .i_coef      (coef),
        .i_init      (init),
        .i_ctl       (ctl),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_valid     (o_out_valid),
        .o_filtered  (o_filtered),
        .o_peak_max  (o_peak_max),
        .o_peak_min  (o_peak_min)
    );

endmodule

### rtl/core/opf_cfg.sv
// ----------------------------------------------------------------------------
// opf_cfg
// Configuration registers; raises a one-cycle reload after each valid write to a defined index.
// ----------------------------------------------------------------------------
module opf_cfg
    import opf_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int VAL_W     = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [VAL_W-1:0]            i_cfg_data,
    output logic [FRAC_BITS:0]          o_coef,
    output logic signed [VAL_W-1:0]     o_init,
    output t_ctl                        o_ctl
);

    localparam logic [FRAC_BITS:0] COEF_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [FRAC_BITS:0]      r_coef;
    logic signed [VAL_W-1:0] r_init;
    logic                    r_peak;
    logic                    r_reload;
    logic [FRAC_BITS:0]      n_coef;

    // clamp coefficient above one
    always_comb begin
        n_coef = i_cfg_data[FRAC_BITS:0];
        if (n_coef > COEF_ONE) begin
            n_coef = COEF_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= '0;
            r_init   <= '0;
            r_peak   <= 1'b0;
            r_reload <= 1'b0;
        end else begin
            r_reload <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_COEF: begin
                        r_coef   <= n_coef;
                        r_reload <= 1'b1;
                    end
                    CFG_INIT: begin
                        r_init   <= signed'(i_cfg_data);
                        r_reload <= 1'b1;
                    end
                    CFG_PEAK: begin
                        r_peak   <= i_cfg_data[0];
                        r_reload <= 1'b1;
                    end
                    default: begin
                        r_reload <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_coef        = r_coef;
    assign o_init        = r_init;
    assign o_ctl.reload  = r_reload;
    assign o_ctl.peak_en = r_peak;

endmodule

### rtl/core/opf_input_stage.sv
// ----------------------------------------------------------------------------
// opf_input_stage
// Input register: forms the weighted input term (1 - c) * x.
// ----------------------------------------------------------------------------
module opf_input_stage #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic                                  o_stall,
    input  logic [FRAC_BITS:0]                    i_coef,
    input  logic                                  i_advance,
    output logic                                  o_valid,
    output logic signed [SAMPLE_BITS+FRAC_BITS:0] o_term
);

    localparam int VAL_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] COEF_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic                      r_valid;
    logic signed [VAL_W:0]     r_term;
    logic [FRAC_BITS:0]        in_weight;
    logic signed [FRAC_BITS+1:0] in_weight_s;
    logic signed [PROD_W-1:0]  prod;
    logic                      accept;

    assign in_weight   = COEF_ONE - i_coef;
    assign in_weight_s = signed'({1'b0, in_weight});
    assign prod        = in_weight_s * i_sample;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_term <= prod[VAL_W:0];
        end
    end

    assign o_valid = r_valid;
    assign o_term  = r_term;

endmodule

### rtl/core/opf_update.sv
// ----------------------------------------------------------------------------
// opf_update
// Recurrence y' = term + floor(c * y), saturation, reload, peak tracking, result item.
// ----------------------------------------------------------------------------
module opf_update
    import opf_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int VAL_W     = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [VAL_W:0]       i_term,
    input  logic [FRAC_BITS:0]          i_coef,
    input  logic signed [VAL_W-1:0]     i_init,
    input  t_ctl                        i_ctl,
    input  logic                        i_out_stall,
    output logic                        o_advance,
    output logic                        o_valid,
    output logic signed [VAL_W-1:0]     o_filtered,
    output logic signed [VAL_W-1:0]     o_peak_max,
    output logic signed [VAL_W-1:0]     o_peak_min
);

    localparam int PROD_W = VAL_W + FRAC_BITS + 2;
    localparam int SUM_W  = VAL_W + FRAC_BITS + 3;

    logic                         r_out_valid;
    logic signed [VAL_W-1:0]      r_y;
    logic signed [VAL_W-1:0]      r_max;
    logic signed [VAL_W-1:0]      r_min;
    logic signed [FRAC_BITS+1:0]  coef_s;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     fb;
    logic signed [SUM_W-1:0]      sum;
    logic                         ovf;
    logic signed [VAL_W-1:0]      n_y;

    assign coef_s = signed'({1'b0, i_coef});
    assign prod   = coef_s * r_y;
    assign fb     = prod >>> FRAC_BITS;
    assign sum    = SUM_W'(fb) + SUM_W'(i_term);
    assign ovf    = (sum[SUM_W-1:VAL_W-1] != '0) && (sum[SUM_W-1:VAL_W-1] != '1);

    always_comb begin
        n_y = sum[VAL_W-1:0];
        if (ovf) begin
            n_y = {sum[SUM_W-1], {(VAL_W-1){!sum[SUM_W-1]}}};
        end
    end

    assign o_advance = i_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y   <= '0;
            r_max <= '0;
            r_min <= '0;
        end else if (i_ctl.reload) begin
            r_y   <= i_init;
            r_max <= i_ctl.peak_en ? i_init : '0;
            r_min <= i_ctl.peak_en ? i_init : '0;
        end else if (o_advance) begin
            r_y <= n_y;
            if (i_ctl.peak_en && (n_y > r_max)) begin
                r_max <= n_y;
            end
            if (i_ctl.peak_en && (n_y < r_min)) begin
                r_min <= n_y;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_y;
    assign o_peak_max = r_max;
    assign o_peak_min = r_min;

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max >= r_min)
        else $error("peak max below peak min");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.reload && !i_ctl.peak_en |=> (r_max == '0) && (r_min == '0))
        else $error("peaks not cleared with tracking off");

    a_peak_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && i_ctl.peak_en && !i_ctl.reload |=> (r_max >= r_y) && (r_min <= r_y))
        else $error("filtered value outside tracked peaks");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_advance && !i_ctl.reload |=> $stable(r_y))
        else $error("filter state moved without an item");

endmodule
